/* rtl/core/ssba_pkg.sv */
// Shared types and constants of the swap slot bitmap allocator.
package ssba_pkg;

  localparam int CFG_W    = 11;
  localparam int SLOT_W   = 10;
  localparam int SEC_W    = 13;
  localparam int CNT_W    = 17;
  localparam int ROW_BITS = 32;
  localparam int ROW_SH   = 5;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NOT_OCC      = 2'd2,
    ST_INSTALL_FAIL = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic rd;
    logic adv_row;
    logic commit;
    logic fail;
    logic emit;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic miss_end;
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/ssba_ctrl.sv */
// Controller state machine of the swap slot bitmap allocator.
module ssba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ssba_pkg::sts_t sts,
  output ssba_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_EMIT   = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.commit = 1'b1;
          state_next = S_EMIT;
        end else if (sts.miss_end) begin
          cmd.fail   = 1'b1;
          state_next = S_REPORT;
        end else begin
          cmd.adv_row = 1'b1;
          state_next  = S_READ;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.step_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/core/ssba_datapath.sv */
// Datapath of the swap slot bitmap allocator: bitmap memory, search and result word.
module ssba_datapath #(
  parameter int NUM_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ssba_pkg::cmd_t                cmd,
  output ssba_pkg::sts_t                sts,
  input  logic [ssba_pkg::CFG_W-1:0]    slot_count,
  input  logic                          mode,
  input  logic [ssba_pkg::SLOT_W-1:0]   slot_index,
  input  logic                          install_ok,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    status,
  output logic [ssba_pkg::SLOT_W-1:0]   slot_number,
  output logic [ssba_pkg::SEC_W-1:0]    sector_address,
  output logic                          last
);

  localparam int RB     = ssba_pkg::ROW_BITS;
  localparam int CW     = ssba_pkg::CNT_W;
  localparam int SW     = ssba_pkg::SEC_W;
  localparam int ROWS   = (NUM_SLOTS + RB - 1) / RB;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int STEP_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam logic [CW-1:0]     NUM_C     = CW'(NUM_SLOTS);
  localparam logic [SW-1:0]     SPS_C     = SW'(SECTORS_PER_SLOT);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SECTORS_PER_SLOT - 1);
  localparam logic [RW-1:0]     ROW_LAST  = RW'(ROWS - 1);

  logic [RB-1:0]          mem [ROWS];
  logic [RB-1:0]          rdata;
  logic [RW-1:0]          row;
  logic                   mode_q;
  logic [ssba_pkg::SLOT_W-1:0] idx_q;
  logic                   ok_q;
  logic [CW-1:0]          slot_sel;
  logic [STEP_W-1:0]      step;
  ssba_pkg::status_t      err_q;

  logic [CW-1:0]          usable;
  logic [CW-1:0]          cnt_ext;
  logic [CW-1:0]          idx_ext;
  logic [CW-1:0]          row_base;
  logic [CW-1:0]          remaining;
  logic [RB-1:0]          in_mask;
  logic [RB-1:0]          free_bits;
  logic [RB-1:0]          bit_sel;
  logic [RB-1:0]          wdata;
  logic [RW-1:0]          waddr;
  logic                   we;
  logic [4:0]             pe;
  logic [4:0]             bitpos;
  logic                   found;
  logic                   idx_bit;
  logic                   idx_in_range;
  logic                   free_ok;
  ssba_pkg::status_t      err_now;
  logic [SW-1:0]          sec_base;

  assign cnt_ext   = CW'(slot_count);
  assign usable    = (cnt_ext > NUM_C) ? NUM_C : cnt_ext;
  assign idx_ext   = CW'(idx_q);
  assign row_base  = CW'(row) << ssba_pkg::ROW_SH;
  assign remaining = usable - row_base;

  always_comb begin
    for (int b = 0; b < RB; b++) begin
      in_mask[b] = (remaining > CW'(b));
    end
  end

  assign free_bits = ~rdata & in_mask;
  assign found     = |free_bits;

  always_comb begin
    pe = '0;
    for (int b = RB - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pe = 5'(b);
      end
    end
  end

  assign idx_bit      = rdata[idx_q[4:0]];
  assign idx_in_range = (idx_ext < usable);
  assign free_ok      = idx_in_range && idx_bit && ok_q;

  always_comb begin
    if (mode_q == ssba_pkg::MODE_ALLOC) begin
      err_now = ssba_pkg::ST_FULL;
    end else if (!idx_in_range || !idx_bit) begin
      err_now = ssba_pkg::ST_NOT_OCC;
    end else begin
      err_now = ssba_pkg::ST_INSTALL_FAIL;
    end
  end

  assign bitpos  = (mode_q == ssba_pkg::MODE_FREE) ? idx_q[4:0] : pe;
  assign bit_sel = RB'(1) << bitpos;

  always_comb begin
    we    = 1'b0;
    waddr = row;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      we    = 1'b1;
      wdata = (mode_q == ssba_pkg::MODE_FREE) ? (rdata & ~bit_sel) : (rdata | bit_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (cmd.capture) begin
      row <= (mode == ssba_pkg::MODE_FREE) ?
             RW'(CW'(slot_index) >> ssba_pkg::ROW_SH) : '0;
    end else if (cmd.clr_wr) begin
      row <= (row == ROW_LAST) ? '0 : row + RW'(1);
    end else if (cmd.adv_row) begin
      row <= row + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      idx_q  <= slot_index;
      ok_q   <= install_ok;
    end
    if (cmd.commit) begin
      slot_sel <= (mode_q == ssba_pkg::MODE_FREE) ? idx_ext : (row_base + CW'(pe));
    end
    if (cmd.fail) begin
      err_q <= err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      step <= '0;
    end else if (cmd.emit) begin
      step <= (step == STEP_LAST) ? '0 : step + STEP_W'(1);
    end
  end

  assign sec_base = slot_sel[SW-1:0] * SPS_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit || cmd.report) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= ssba_pkg::ST_OK;
      slot_number    <= slot_sel[ssba_pkg::SLOT_W-1:0];
      sector_address <= sec_base + SW'(step);
      last           <= (step == STEP_LAST);
    end else if (cmd.report) begin
      status         <= err_q;
      slot_number    <= (mode_q == ssba_pkg::MODE_FREE) ? idx_q : '0;
      sector_address <= '0;
      last           <= 1'b1;
    end
  end

  assign sts.clr_last  = (row == ROW_LAST);
  assign sts.hit       = (mode_q == ssba_pkg::MODE_FREE) ? free_ok : found;
  assign sts.miss_end  = (mode_q == ssba_pkg::MODE_FREE) ||
                         (remaining <= CW'(RB));
  assign sts.step_last = (step == STEP_LAST);
  assign sts.out_free  = !result_valid || result_ready;

endmodule

/* rtl/core/swap_slot_bitmap_allocator.sv */
// Top level of the swap slot bitmap allocator with its configuration register.
// After reset a clearing pass empties the bitmap row by row; no word is taken.
// Allocate: the bitmap is searched 32 slots per row; each row is read from memory, then checked.
// A successful item then gives SECTORS_PER_SLOT result words, one a cycle from the result register
// while result_ready stays high. A failure gives one result word; a free reads and checks one row.
// One item is in work at a time; the slot count register is cleared to 1024 by reset.
module swap_slot_bitmap_allocator #(
  parameter int NUM_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        mode,
  input  logic [ssba_pkg::SLOT_W-1:0] slot_index,
  input  logic                        install_ok,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [1:0]                  status,
  output logic [ssba_pkg::SLOT_W-1:0] slot_number,
  output logic [ssba_pkg::SEC_W-1:0]  sector_address,
  output logic                        last
);

  logic [ssba_pkg::CFG_W-1:0] slot_count;
  ssba_pkg::cmd_t             cmd;
  ssba_pkg::sts_t             sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= ssba_pkg::CFG_W'(1024);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      slot_count <= pwdata[ssba_pkg::CFG_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : 32'(slot_count);

  ssba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssba_datapath #(
    .NUM_SLOTS        (NUM_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .slot_count     (slot_count),
    .mode           (mode),
    .slot_index     (slot_index),
    .install_ok     (install_ok),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .status         (status),
    .slot_number    (slot_number),
    .sector_address (sector_address),
    .last           (last)
  );

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("a second word was accepted while an item was in work");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ssba_pkg::ST_OK) |-> last)
    else $error("an error result word is not marked last");

  a_commit_fail: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && cmd.fail))
    else $error("bitmap update and failure report issued together");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.report) |-> sts.out_free)
    else $error("result register loaded while its word was still held");
`endif

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the swap slot bitmap allocator: directed and random traffic.
`timescale 1ns / 100ps

module tb;

  localparam int NSLOTS = 1024;
  localparam int SECTORS = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
  localparam logic [2:0] REG_SPARE = 3'd4;

  typedef struct {
    ssba_pkg::status_t status;
    logic [ssba_pkg::SLOT_W-1:0] slot;
    logic [ssba_pkg::SEC_W-1:0] sector;
    logic last;
  } sector_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_ready;
  logic mode = 1'b0;
  logic [ssba_pkg::SLOT_W-1:0] slot_index = '0;
  logic install_ok = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [1:0] status;
  logic [ssba_pkg::SLOT_W-1:0] slot_number;
  logic [ssba_pkg::SEC_W-1:0] sector_address;
  logic last;

  bit slot_busy [NSLOTS];
  logic [ssba_pkg::CFG_W-1:0] slot_limit = 11'd1024;
  sector_word_t pending_words[$];
  int send_gap_pct = 26;
  int recv_stall_pct = 58;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  swap_slot_bitmap_allocator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .mode(mode), .slot_index(slot_index), .install_ok(install_ok),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .slot_number(slot_number),
    .sector_address(sector_address), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int usable_slots();
    return (slot_limit > NSLOTS) ? NSLOTS : int'(slot_limit);
  endfunction

  function automatic void push_sectors(input int s);
    sector_word_t w;
    for (int k = 0; k < SECTORS; k++) begin
      w.status = ssba_pkg::ST_OK;
      w.slot = s[ssba_pkg::SLOT_W-1:0];
      w.sector = ssba_pkg::SEC_W'(s * SECTORS + k);
      w.last = (k == SECTORS - 1);
      pending_words.push_back(w);
    end
  endfunction

  function automatic void push_failure(input ssba_pkg::status_t st,
                                       input logic [ssba_pkg::SLOT_W-1:0] s);
    sector_word_t w;
    w.status = st;
    w.slot = s;
    w.sector = '0;
    w.last = 1'b1;
    pending_words.push_back(w);
  endfunction

  function automatic void allocate_or_free(input ssba_pkg::mode_t m,
                                           input logic [ssba_pkg::SLOT_W-1:0] idx,
                                           input logic ok);
    int count;
    bit found;
    count = usable_slots();
    found = 0;
    if (m == ssba_pkg::MODE_ALLOC) begin
      for (int s = 0; s < count && !found; s++) begin
        if (!slot_busy[s]) begin
          found = 1;
          slot_busy[s] = 1;
          push_sectors(s);
        end
      end
      if (!found) push_failure(ssba_pkg::ST_FULL, '0);
    end else if (int'(idx) >= count || !slot_busy[idx]) begin
      push_failure(ssba_pkg::ST_NOT_OCC, idx);
    end else if (!ok) begin
      push_failure(ssba_pkg::ST_INSTALL_FAIL, idx);
    end else begin
      slot_busy[idx] = 0;
      push_sectors(idx);
    end
  endfunction

  task automatic send_word(input ssba_pkg::mode_t m, input logic [ssba_pkg::SLOT_W-1:0] idx,
                           input logic ok);
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    slot_index <= idx;
    install_ok <= ok;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    allocate_or_free(m, idx, ok);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_SLOT_COUNT) slot_limit = value[ssba_pkg::CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_first_fit_and_free();
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd1, 1'b0);
    send_word(ssba_pkg::MODE_FREE, 10'd1, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd1, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd1023, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd0, 1'b0);
    send_word(ssba_pkg::MODE_ALLOC, 10'd1023, 1'b0);
  endtask

  task automatic test_slot_count_limits();
    wait_idle();
    write_reg(REG_SLOT_COUNT, 32'd0);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd0, 1'b1);
    wait_idle();
    write_reg(REG_SPARE, 32'd5);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    wait_idle();
    write_reg(REG_SLOT_COUNT, 32'd3);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd2, 1'b1);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    wait_idle();
    write_reg(REG_SLOT_COUNT, 32'd2047);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
    send_word(ssba_pkg::MODE_FREE, 10'd1023, 1'b1);
    wait_idle();
    write_reg(REG_SLOT_COUNT, 32'd1024);
    send_word(ssba_pkg::MODE_ALLOC, 10'd0, 1'b1);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                     input logic [ssba_pkg::CFG_W-1:0] count,
                                     input int n_items);
    int unsigned pick;
    int busy_list[$];
    logic [ssba_pkg::SLOT_W-1:0] idx;
    logic ok;
    wait_idle();
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    write_reg(REG_SLOT_COUNT, 32'(count));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      idx = ssba_pkg::SLOT_W'($urandom_range(NSLOTS - 1));
      ok = 1'($urandom_range(1));
      if (pick < 45) begin
        send_word(ssba_pkg::MODE_ALLOC, idx, ok);
      end else begin
        busy_list.delete();
        for (int s = 0; s < usable_slots(); s++) begin
          if (slot_busy[s]) busy_list.push_back(s);
        end
        if (pick < 85 && busy_list.size() != 0) begin
          idx = ssba_pkg::SLOT_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
          ok = ($urandom_range(9) != 0);
        end
        send_word(ssba_pkg::MODE_FREE, idx, ok);
      end
    end
  endtask

  always @(posedge clk) begin
    sector_word_t want;
    if (result_valid && result_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: status %0d slot %0d sector %0d last %0d",
                 $time, status, slot_number, sector_address, last);
        fail_cnt++;
      end else begin
        want = pending_words.pop_front();
        if (status !== want.status || slot_number !== want.slot ||
            sector_address !== want.sector || last !== want.last) begin
          $display("%0t: mismatch: expected status %0d slot %0d sector %0d last %0d",
                   $time, want.status, want.slot, want.sector, want.last);
          $display("%0t:           actual   status %0d slot %0d sector %0d last %0d",
                   $time, status, slot_number, sector_address, last);
          fail_cnt++;
        end
      end
    end
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
    if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("swap_slot_bitmap_allocator test failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_first_fit_and_free();
    test_slot_count_limits();
    test_random_traffic(26, 58, 11'($urandom_range(1, 24)), 75);
    test_random_traffic(58, 26, 11'($urandom_range(4, 40)), 75);
    test_random_traffic(0, 0, 11'd1024, 70);
    wait_idle();
    if (fail_cnt == 0) begin
      $display("swap_slot_bitmap_allocator test passed");
    end else begin
      $display("swap_slot_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule
